@@ hdl/swc_pkg.sv @@
// Shared types and constants for the swept circle actor contact block.
// Depends on nothing; every other file imports it.
package swc_pkg;

  // fixed point
  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int QW        = FRAC_BITS + 1;              // fraction 0..ONE
  localparam int SCALE_LOW = (35 * ONE + 50) / 100;
  localparam int SCALE_OFF = (999 * ONE + 999) / 1000;   // scale at or above: no test

  // configuration registers
  localparam int REG_PLAYER = 0;
  localparam int REG_NPC    = 1;
  localparam int CFG_AW     = 3;

  // stream widths
  localparam int IN_TDATA_W  = 320;
  localparam int OUT_TDATA_W = 56;

  // datapath widths
  localparam int AW     = 64;                 // |m|^2
  localparam int BW     = 66 + FRAC_BITS;     // ONE * (r . m)
  localparam int CW     = 64 + 2 * FRAC_BITS; // ONE^2 * |r|^2
  localparam int RSW    = 26 + QW;            // summed radius
  localparam int RW     = 2 * RSW;            // radius squared
  localparam int GW     = 104;                // distance minus radius squared
  localparam int FW     = BW + 3;             // distance slope
  localparam int HW     = AW + QW + 1;        // A * n
  localparam int PW     = 34 + FRAC_BITS;     // position at contact
  localparam int SHW    = $clog2(PW);
  localparam int NMAG_W = 31;                 // normalized component magnitude
  localparam int LENW   = 2 * NMAG_W + 1;
  localparam int NORM_SH = 30;
  localparam int NW     = 96;
  localparam int NLW    = 16;                 // normal search result

  typedef struct packed {
    logic [QW-1:0] player;
    logic [QW-1:0] npc;
  } scale_t;

  typedef struct packed {
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_z;
    logic signed [31:0] motion_x;
    logic signed [31:0] motion_y;
    logic signed [31:0] motion_z;
    logic [24:0]        half_a_x;
    logic [24:0]        half_a_y;
    logic [24:0]        half_b_x;
    logic [24:0]        half_b_y;
    logic [25:0]        vertical_reach;
    logic               involves_player;
  } req_t;

  // query geometry carried down the pipe; motion already negated
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [32:0] mx;
    logic signed [32:0] my;
    logic signed [32:0] mz;
    logic [25:0]        reach;
  } geom_t;

  typedef struct packed {
    logic               live;
    logic [AW-1:0]      a;
    logic signed [BW-1:0] cb;
    logic signed [GW-1:0] g0;   // dist2(0) - rsq
    logic signed [GW-1:0] gm;   // dist2(-1) - rsq
    logic signed [FW-1:0] f0;   // slope at grid point 0
    geom_t              geo;
  } coef_t;

  typedef struct packed {
    logic          live;
    logic [QW-1:0] q;
    geom_t         geo;
  } hitq_t;

  typedef struct packed {
    logic               hit;
    logic [QW-1:0]      frac;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } res_t;

endpackage

@@ hdl/swc_cfg.sv @@
// APB-style register file holding the two footprint scales.
// Depends on swc_pkg.
module swc_cfg import swc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output scale_t            scale_o
);

  scale_t        scale_r, scale_nxt;
  logic [QW-1:0] wval;
  logic          wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;

  // saturate written value to the legal scale range
  always_comb begin
    wval = cfg_pwdata[QW-1:0];
    if (wval < QW'(SCALE_LOW)) wval = QW'(SCALE_LOW);
    else if (wval > QW'(ONE)) wval = QW'(ONE);
    scale_nxt = scale_r;
    if (wr) begin
      case (int'(cfg_paddr[2]))
        REG_PLAYER: scale_nxt.player = wval;
        REG_NPC:    scale_nxt.npc    = wval;
        default:    scale_nxt = scale_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r.player <= QW'(ONE);
      scale_r.npc    <= QW'(ONE);
    end else begin
      scale_r <= scale_nxt;
    end
  end

  // read back
  always_comb begin
    case (int'(cfg_paddr[2]))
      REG_PLAYER: cfg_prdata = 32'(scale_r.player);
      REG_NPC:    cfg_prdata = 32'(scale_r.npc);
      default:    cfg_prdata = '0;
    endcase
  end

  assign scale_o = scale_r;

endmodule

@@ hdl/swc_setup.sv @@
// Front end: captures a query and builds the quadratic coefficients of the
// squared horizontal distance over the fraction grid. Five stages. Uses swc_pkg.
module swc_setup import swc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   valid_i,
  input  req_t   req_i,
  input  scale_t scale_i,
  output logic   valid_o,
  output coef_t  coef_o
);

  localparam int RH = RSW - 32;

  logic [4:0] v_r;

  // stage 0: geometry, radii, scale
  geom_t         geo0_r, geo0_nxt;
  logic [25:0]   rab0_r, rab0_nxt;
  logic [QW-1:0] sc0_r, sc0_nxt;
  logic          off0_r, off0_nxt;
  // stage 1: products
  geom_t               geo1_r;
  logic                off1_r;
  logic [RSW-1:0]      rsum1_r, rsum1_nxt;
  logic signed [65:0]  mmx1_r, mmy1_r, mmx1_nxt, mmy1_nxt;
  logic signed [64:0]  rmx1_r, rmy1_r, rmx1_nxt, rmy1_nxt;
  logic signed [63:0]  rrx1_r, rry1_r, rrx1_nxt, rry1_nxt;
  // stage 2: sums and radius partials
  geom_t                geo2_r;
  logic                 off2_r;
  logic [AW-1:0]        a2_r, a2_nxt;
  logic signed [BW-1:0] b2_r, b2_nxt;
  logic [CW-1:0]        c2_r, c2_nxt;
  logic [63:0]          pl2_r, pl2_nxt;
  logic [RSW-1:0]       pm2_r, pm2_nxt;
  logic [2*RH-1:0]      ph2_r, ph2_nxt;
  logic signed [65:0]   bs;
  // stage 3: radius squared
  geom_t                geo3_r;
  logic                 off3_r;
  logic [AW-1:0]        a3_r;
  logic signed [BW-1:0] b3_r;
  logic [CW-1:0]        c3_r;
  logic [RW-1:0]        r3_r, r3_nxt;
  // stage 4: seeds
  coef_t                coef_r, coef_nxt;
  logic signed [GW-1:0] cg, rg, ag, bg;

  // stage 0
  always_comb begin
    logic [24:0] ra, rb;
    ra = (req_i.half_a_x > req_i.half_a_y) ? req_i.half_a_x : req_i.half_a_y;
    rb = (req_i.half_b_x > req_i.half_b_y) ? req_i.half_b_x : req_i.half_b_y;
    geo0_nxt.rx    = req_i.rel_x;
    geo0_nxt.ry    = req_i.rel_y;
    geo0_nxt.rz    = req_i.rel_z;
    geo0_nxt.mx    = -33'(req_i.motion_x);
    geo0_nxt.my    = -33'(req_i.motion_y);
    geo0_nxt.mz    = -33'(req_i.motion_z);
    geo0_nxt.reach = req_i.vertical_reach;
    rab0_nxt = 26'(ra) + 26'(rb);
    sc0_nxt  = req_i.involves_player ? scale_i.player : scale_i.npc;
    off0_nxt = (sc0_nxt >= QW'(SCALE_OFF));
  end

  // stage 1
  always_comb begin
    rsum1_nxt = RSW'(rab0_r) * RSW'(sc0_r);
    mmx1_nxt  = 66'(geo0_r.mx) * 66'(geo0_r.mx);
    mmy1_nxt  = 66'(geo0_r.my) * 66'(geo0_r.my);
    rmx1_nxt  = 65'(geo0_r.rx) * 65'(geo0_r.mx);
    rmy1_nxt  = 65'(geo0_r.ry) * 65'(geo0_r.my);
    rrx1_nxt  = 64'(geo0_r.rx) * 64'(geo0_r.rx);
    rry1_nxt  = 64'(geo0_r.ry) * 64'(geo0_r.ry);
  end

  // stage 2
  always_comb begin
    a2_nxt  = mmx1_r[AW-1:0] + mmy1_r[AW-1:0];
    bs      = 66'(rmx1_r) + 66'(rmy1_r);
    b2_nxt  = $signed({bs, {FRAC_BITS{1'b0}}});
    c2_nxt  = {rrx1_r[63:0] + rry1_r[63:0], {(2 * FRAC_BITS){1'b0}}};
    pl2_nxt = 64'(rsum1_r[31:0]) * 64'(rsum1_r[31:0]);
    pm2_nxt = RSW'(rsum1_r[RSW-1:32]) * RSW'(rsum1_r[31:0]);
    ph2_nxt = (2*RH)'(rsum1_r[RSW-1:32]) * (2*RH)'(rsum1_r[RSW-1:32]);
  end

  // stage 3
  assign r3_nxt = RW'(pl2_r) + (RW'(pm2_r) << 33) + (RW'(ph2_r) << 64);

  // stage 4: g0 = C - R, gm = C - R + A - 2B, f0 = 2B - A
  always_comb begin
    cg = GW'($signed({1'b0, c3_r}));
    rg = GW'($signed({1'b0, r3_r}));
    ag = GW'($signed({1'b0, a3_r}));
    bg = GW'(b3_r);
    coef_nxt.live = ~off3_r;
    coef_nxt.a    = a3_r;
    coef_nxt.cb   = b3_r;
    coef_nxt.g0   = cg - rg;
    coef_nxt.gm   = cg - rg + ag - (bg <<< 1);
    coef_nxt.f0   = (FW'(b3_r) <<< 1) - FW'($signed({1'b0, a3_r}));
    coef_nxt.geo  = geo3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[3:0], valid_i};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo0_r  <= geo0_nxt;  rab0_r <= rab0_nxt; sc0_r <= sc0_nxt; off0_r <= off0_nxt;
      geo1_r  <= geo0_r;    off1_r <= off0_r;   rsum1_r <= rsum1_nxt;
      mmx1_r  <= mmx1_nxt;  mmy1_r <= mmy1_nxt;
      rmx1_r  <= rmx1_nxt;  rmy1_r <= rmy1_nxt;
      rrx1_r  <= rrx1_nxt;  rry1_r <= rry1_nxt;
      geo2_r  <= geo1_r;    off2_r <= off1_r;
      a2_r    <= a2_nxt;    b2_r <= b2_nxt;     c2_r <= c2_nxt;
      pl2_r   <= pl2_nxt;   pm2_r <= pm2_nxt;   ph2_r <= ph2_nxt;
      geo3_r  <= geo2_r;    off3_r <= off2_r;
      a3_r    <= a2_r;      b3_r <= b2_r;       c3_r <= c2_r;   r3_r <= r3_nxt;
      coef_r  <= coef_nxt;
    end
  end

  assign valid_o = v_r[4];
  assign coef_o  = coef_r;

endmodule

@@ hdl/swc_root.sv @@
// Contact fraction search: one grid bit per stage, first for the point of
// closest approach, then for the first touching point. Uses swc_pkg.
module swc_root import swc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  valid_i,
  input  coef_t coef_i,
  output logic  valid_o,
  output hitq_t hq_o
);

  typedef struct packed {
    logic                 live;
    logic [QW-1:0]        n;
    logic signed [FW-1:0] f;   // slope at n
    logic signed [GW-1:0] g;   // dist2(n) - rsq
    logic signed [HW-1:0] h;   // A * n
    logic signed [GW-1:0] gm;
    logic [AW-1:0]        a;
    logic signed [BW-1:0] cb;
    geom_t                geo;
  } s1_t;

  typedef struct packed {
    logic                 live;
    logic [QW-1:0]        lo1;
    logic [QW-1:0]        n;
    logic signed [GW-1:0] gm;  // dist2(n - 1) - rsq
    logic signed [HW-1:0] hm;  // A * (n - 1)
    logic [AW-1:0]        a;
    logic signed [BW-1:0] cb;
    geom_t                geo;
  } s2_t;

  s1_t     s1_r [QW];
  s1_t     s1_nxt [QW];
  logic [QW-1:0] v1_r;
  s2_t     chk_r, chk_nxt;
  logic    vc_r;
  s2_t     s2_r [QW];
  s2_t     s2_nxt [QW];
  logic [QW-1:0] v2_r;

  // closest approach: count grid points where the distance still falls
  always_comb begin
    s1_t cur;
    logic [QW-1:0] nc;
    logic signed [FW-1:0] fc;
    logic signed [GW-1:0] ag;
    logic signed [HW-1:0] ah;
    int sb;
    for (int k = 0; k < QW; k++) begin
      sb = QW - 1 - k;
      if (k == 0) begin
        cur.live = coef_i.live;
        cur.n    = '0;
        cur.f    = coef_i.f0;
        cur.g    = coef_i.g0;
        cur.h    = '0;
        cur.gm   = coef_i.gm;
        cur.a    = coef_i.a;
        cur.cb   = coef_i.cb;
        cur.geo  = coef_i.geo;
      end else begin
        cur = s1_r[k-1];
      end
      ag = GW'($signed({1'b0, cur.a}));
      ah = HW'($signed({1'b0, cur.a}));
      nc = cur.n | (QW'(1) << sb);
      fc = cur.f + (FW'($signed({1'b0, cur.a})) <<< (sb + 1));
      s1_nxt[k] = cur;
      if ((nc <= QW'(ONE)) && (fc < 0)) begin
        s1_nxt[k].n = nc;
        s1_nxt[k].f = fc;
        s1_nxt[k].g = cur.g + (GW'(cur.h) <<< (sb + 1)) + (ag <<< (2 * sb))
                      + (GW'(cur.cb) <<< (sb + 1));
        s1_nxt[k].h = cur.h + (ah <<< sb);
      end
    end
  end

  // no touch at the closest point means no hit; seed the second search
  always_comb begin
    chk_nxt.live = s1_r[QW-1].live & (s1_r[QW-1].g <= 0);
    chk_nxt.lo1  = s1_r[QW-1].n;
    chk_nxt.n    = '0;
    chk_nxt.gm   = s1_r[QW-1].gm;
    chk_nxt.hm   = -HW'($signed({1'b0, s1_r[QW-1].a}));
    chk_nxt.a    = s1_r[QW-1].a;
    chk_nxt.cb   = s1_r[QW-1].cb;
    chk_nxt.geo  = s1_r[QW-1].geo;
  end

  // first touch: count grid points before lo1 that are still apart
  always_comb begin
    s2_t cur;
    logic [QW-1:0] nc;
    logic signed [GW-1:0] gc;
    logic signed [GW-1:0] ag;
    logic signed [HW-1:0] ah;
    int sb;
    for (int k = 0; k < QW; k++) begin
      sb = QW - 1 - k;
      if (k == 0) cur = chk_r;
      else cur = s2_r[k-1];
      ag = GW'($signed({1'b0, cur.a}));
      ah = HW'($signed({1'b0, cur.a}));
      nc = cur.n | (QW'(1) << sb);
      gc = cur.gm + (GW'(cur.hm) <<< (sb + 1)) + (ag <<< (2 * sb))
           + (GW'(cur.cb) <<< (sb + 1));
      s2_nxt[k] = cur;
      if ((nc <= cur.lo1) && (gc > 0)) begin
        s2_nxt[k].n  = nc;
        s2_nxt[k].gm = gc;
        s2_nxt[k].hm = cur.hm + (ah <<< sb);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= '0;
      vc_r <= 1'b0;
      v2_r <= '0;
    end else if (en) begin
      v1_r <= {v1_r[QW-2:0], valid_i};
      vc_r <= v1_r[QW-1];
      v2_r <= {v2_r[QW-2:0], vc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        s1_r[k] <= s1_nxt[k];
        s2_r[k] <= s2_nxt[k];
      end
      chk_r <= chk_nxt;
    end
  end

  assign valid_o   = v2_r[QW-1];
  assign hq_o.live = s2_r[QW-1].live;
  assign hq_o.q    = s2_r[QW-1].n;
  assign hq_o.geo  = s2_r[QW-1].geo;

endmodule

@@ hdl/swc_normal.sv @@
// Back end: vertical reach check, contact offset, and the unit normal found
// by a per-bit square search; holds the result register. Uses swc_pkg.
module swc_normal import swc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  valid_i,
  input  hitq_t hq_i,
  output logic  valid_o,
  output res_t  res_o
);

  typedef struct packed {
    logic              live;
    logic [QW-1:0]     q;
    logic              sx;
    logic              sy;
    logic [LENW-1:0]   len2;
    logic [NW-1:0]     rhsx;
    logic [NW-1:0]     rhsy;
    logic [NLW-1:0]    lx;
    logic [NLW-1:0]    ly;
    logic [NW-1:0]     ssx;
    logic [NW-1:0]     ssy;
    logic [NW-1:0]     tx;
    logic [NW-1:0]     ty;
  } nm_t;

  logic [5:0] v_r;
  logic [NLW-1:0] vs_r;
  logic vo_r;

  // stage 0: positions at contact
  logic                 live0_r;
  logic [QW-1:0]        q0_r;
  geom_t                geo0_r;
  logic signed [PW-1:0] pz0_r, px0_r, py0_r, pz0_nxt, px0_nxt, py0_nxt;
  // stage 1: reach check, degenerate normal
  logic                 live1_r, live1_nxt;
  logic [QW-1:0]        q1_r;
  logic signed [PW-1:0] nx1_r, ny1_r, nx1_nxt, ny1_nxt;
  logic signed [PW-1:0] rch;
  // stage 2: magnitudes
  logic                 live2_r;
  logic [QW-1:0]        q2_r;
  logic                 sx2_r, sy2_r;
  logic [PW-1:0]        ux2_r, uy2_r;
  // stage 3: normalize below 2^31
  logic                 live3_r;
  logic [QW-1:0]        q3_r;
  logic                 sx3_r, sy3_r;
  logic [NMAG_W-1:0]    ux3_r, uy3_r, ux3_nxt, uy3_nxt;
  // stage 4: squares
  logic                 live4_r;
  logic [QW-1:0]        q4_r;
  logic                 sx4_r, sy4_r;
  logic [2*NMAG_W-1:0]  sqx4_r, sqy4_r;
  // stage 5: search seed
  nm_t                  n5_r, n5_nxt;
  // search stages
  nm_t                  ns_r [NLW];
  nm_t                  ns_nxt [NLW];
  res_t                 res_r, res_nxt;

  // stage 0
  always_comb begin
    logic signed [PW-1:0] qs;
    qs = PW'($signed({1'b0, hq_i.q}));
    pz0_nxt = (PW'(hq_i.geo.rz) <<< FRAC_BITS) + PW'(hq_i.geo.mz) * qs;
    px0_nxt = (PW'(hq_i.geo.rx) <<< FRAC_BITS) + PW'(hq_i.geo.mx) * qs;
    py0_nxt = (PW'(hq_i.geo.ry) <<< FRAC_BITS) + PW'(hq_i.geo.my) * qs;
  end

  // stage 1
  always_comb begin
    rch = PW'($signed({1'b0, geo0_r.reach, {FRAC_BITS{1'b0}}}));
    live1_nxt = live0_r & ~((pz0_r > rch) | (pz0_r < -rch));
    nx1_nxt = px0_r;
    ny1_nxt = py0_r;
    if ((px0_r == '0) && (py0_r == '0)) begin
      // on the center: fall back to the direction of travel
      nx1_nxt = -PW'(geo0_r.mx);
      ny1_nxt = -PW'(geo0_r.my);
      if ((geo0_r.mx == '0) && (geo0_r.my == '0)) live1_nxt = 1'b0;
    end
  end

  // stage 3: leading one of the wider component sets the shift
  always_comb begin
    logic [PW-1:0]  orv;
    logic [SHW-1:0] msb;
    logic [SHW-1:0] sh;
    orv = ux2_r | uy2_r;
    msb = '0;
    for (int i = 0; i < PW; i++) begin
      if (orv[i]) msb = SHW'(i);
    end
    sh = (msb > SHW'(NMAG_W - 1)) ? (msb - SHW'(NMAG_W - 1)) : '0;
    ux3_nxt = NMAG_W'(ux2_r >> sh);
    uy3_nxt = NMAG_W'(uy2_r >> sh);
  end

  // stage 5
  always_comb begin
    n5_nxt.live = live4_r;
    n5_nxt.q    = q4_r;
    n5_nxt.sx   = sx4_r;
    n5_nxt.sy   = sy4_r;
    n5_nxt.len2 = LENW'(sqx4_r) + LENW'(sqy4_r);
    n5_nxt.rhsx = NW'(sqx4_r) << NORM_SH;
    n5_nxt.rhsy = NW'(sqy4_r) << NORM_SH;
    n5_nxt.lx   = '0;
    n5_nxt.ly   = '0;
    n5_nxt.ssx  = '0;
    n5_nxt.ssy  = '0;
    n5_nxt.tx   = '0;
    n5_nxt.ty   = '0;
  end

  // largest l with l^2 * len2 <= u^2 * 2^30, one bit per stage
  always_comb begin
    nm_t cur;
    logic [NW-1:0] lw, scx, scy;
    int sb;
    for (int k = 0; k < NLW; k++) begin
      sb = NLW - 1 - k;
      if (k == 0) cur = n5_r;
      else cur = ns_r[k-1];
      lw  = NW'(cur.len2);
      scx = cur.ssx + (cur.tx << (sb + 1)) + (lw << (2 * sb));
      scy = cur.ssy + (cur.ty << (sb + 1)) + (lw << (2 * sb));
      ns_nxt[k] = cur;
      if (scx <= cur.rhsx) begin
        ns_nxt[k].lx  = cur.lx | (NLW'(1) << sb);
        ns_nxt[k].ssx = scx;
        ns_nxt[k].tx  = cur.tx + (lw << sb);
      end
      if (scy <= cur.rhsy) begin
        ns_nxt[k].ly  = cur.ly | (NLW'(1) << sb);
        ns_nxt[k].ssy = scy;
        ns_nxt[k].ty  = cur.ty + (lw << sb);
      end
    end
  end

  // result: saturate, apply sign, zero on miss
  always_comb begin
    logic [14:0] mx_s, my_s;
    mx_s = (ns_r[NLW-1].lx > NLW'(32767)) ? 15'h7FFF : ns_r[NLW-1].lx[14:0];
    my_s = (ns_r[NLW-1].ly > NLW'(32767)) ? 15'h7FFF : ns_r[NLW-1].ly[14:0];
    res_nxt = '0;
    if (ns_r[NLW-1].live) begin
      res_nxt.hit  = 1'b1;
      res_nxt.frac = ns_r[NLW-1].q;
      res_nxt.nx   = ns_r[NLW-1].sx ? -16'($signed({1'b0, mx_s}))
                                    : 16'($signed({1'b0, mx_s}));
      res_nxt.ny   = ns_r[NLW-1].sy ? -16'($signed({1'b0, my_s}))
                                    : 16'($signed({1'b0, my_s}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vs_r <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[4:0], valid_i};
      vs_r <= {vs_r[NLW-2:0], v_r[5]};
      vo_r <= vs_r[NLW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      live0_r <= hq_i.live; q0_r <= hq_i.q; geo0_r <= hq_i.geo;
      pz0_r <= pz0_nxt; px0_r <= px0_nxt; py0_r <= py0_nxt;
      live1_r <= live1_nxt; q1_r <= q0_r; nx1_r <= nx1_nxt; ny1_r <= ny1_nxt;
      live2_r <= live1_r; q2_r <= q1_r;
      sx2_r <= nx1_r < 0; sy2_r <= ny1_r < 0;
      ux2_r <= (nx1_r < 0) ? PW'(-nx1_r) : PW'(nx1_r);
      uy2_r <= (ny1_r < 0) ? PW'(-ny1_r) : PW'(ny1_r);
      live3_r <= live2_r; q3_r <= q2_r; sx3_r <= sx2_r; sy3_r <= sy2_r;
      ux3_r <= ux3_nxt; uy3_r <= uy3_nxt;
      live4_r <= live3_r; q4_r <= q3_r; sx4_r <= sx3_r; sy4_r <= sy3_r;
      sqx4_r <= (2*NMAG_W)'(ux3_r) * (2*NMAG_W)'(ux3_r);
      sqy4_r <= (2*NMAG_W)'(uy3_r) * (2*NMAG_W)'(uy3_r);
      n5_r <= n5_nxt;
      for (int k = 0; k < NLW; k++) ns_r[k] <= ns_nxt[k];
      res_r <= res_nxt;
    end
  end

  assign valid_o = vo_r;
  assign res_o   = res_r;

endmodule

@@ hdl/swept_circle_actor_contact.sv @@
// Swept circle versus circle actor contact test, top level.
// Depends on swc_pkg, swc_cfg, swc_setup, swc_root and swc_normal.
//
// Usage:
//   in_*  stream: one beat is one query (offset, inverted motion, half
//         extents, vertical reach in tdata; involves_player in tuser).
//   out_* stream: one beat per query; tuser carries hit, tdata the contact
//         fraction and the Q1.15 horizontal normal (all zero on a miss).
//   cfg_* APB port: player_scale at 0x0, npc_scale at 0x4, saturated to
//         0.35..1.0 on write; write only while the pipe is empty.
// From input beat to output beat the pipe runs through 5 setup stages,
// 17 + 1 + 17 stages of the two fraction searches (one grid bit each),
// 6 contact/normalize stages, 16 normal search stages (one bit each) and
// the result register. Throughput is one query per cycle unless out_tready stalls.
// Reset clears all valid bits and sets both scales to 1.0.
// When out_tready is low with a beat waiting, the whole pipe holds and
// in_tready drops in the same cycle; nothing is lost or repeated.
module swept_circle_actor_contact import swc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // rel_x, rel_y, rel_z, motion_x, motion_y, motion_z, half_a_x, half_a_y,
  // half_b_x, half_b_y, vertical_reach, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // involves_player
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // hit_fraction, normal_x, normal_y, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // hit
  output logic                   out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  scale_t scale;
  req_t   req;
  coef_t  coef;
  hitq_t  hq;
  res_t   res;
  logic   en, v_coef, v_hq;

  // whole pipe advances unless a result waits on a stalled receiver
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  // unpack input beat
  assign req.rel_x           = in_tdata[31:0];
  assign req.rel_y           = in_tdata[63:32];
  assign req.rel_z           = in_tdata[95:64];
  assign req.motion_x        = in_tdata[127:96];
  assign req.motion_y        = in_tdata[159:128];
  assign req.motion_z        = in_tdata[191:160];
  assign req.half_a_x        = in_tdata[216:192];
  assign req.half_a_y        = in_tdata[241:217];
  assign req.half_b_x        = in_tdata[266:242];
  assign req.half_b_y        = in_tdata[291:267];
  assign req.vertical_reach  = in_tdata[317:292];
  assign req.involves_player = in_tuser;

  swc_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .scale_o(scale)
  );

  swc_setup u_setup (
    .clk, .rst_n, .en, .valid_i(in_tvalid & in_tready), .req_i(req),
    .scale_i(scale), .valid_o(v_coef), .coef_o(coef)
  );

  swc_root u_root (
    .clk, .rst_n, .en, .valid_i(v_coef), .coef_i(coef),
    .valid_o(v_hq), .hq_o(hq)
  );

  swc_normal u_normal (
    .clk, .rst_n, .en, .valid_i(v_hq), .hq_i(hq),
    .valid_o(out_tvalid), .res_o(res)
  );

  // pack result beat
  assign out_tdata = {7'b0, res.ny, res.nx, res.frac};
  assign out_tuser = res.hit;

endmodule

@@ hdl/swc_checker.sv @@
// Port-level checks for the contact block, bound to the top level.
// Depends on swc_pkg and swept_circle_actor_contact.
module swc_checker import swc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   cfg_psel,
  input logic                   cfg_penable,
  input logic                   cfg_pwrite,
  input logic [CFG_AW-1:0]      cfg_paddr,
  input logic [31:0]            cfg_pwdata,
  input logic [31:0]            cfg_prdata,
  input logic                   cfg_pready
);

  // a stalled result beat stays and holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat dropped or changed under stall");

  // a miss reports zero fraction and normal
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero payload");

  // contact fraction never exceeds one
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[QW-1:0] <= QW'(ONE))
    else $error("contact fraction out of range");

  // input is refused only while a result waits on the receiver
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without back pressure");

endmodule

bind swept_circle_actor_contact swc_checker u_swc_checker (.*);
